// ===== rtl/hecd_pkg.sv =====
// Shared widths, constants and control types of the heating ETA countdown tracker.
package hecd_pkg;

  localparam int LocalW = 48;
  localparam int EpochW = 47;
  localparam int DlW    = 58;
  localparam int PmW    = 10;
  localparam int NumW   = 68;
  localparam int CntW   = 7;
  localparam int MopW   = 48;
  localparam int ProdW  = 58;
  localparam int SumW   = 60;

  localparam logic [DlW-1:0]       DlMax        = '1;
  localparam logic signed [10:0]  UsPerMs      = 11'sd1000;
  localparam logic [PmW-1:0]      PermilleFull = 10'd1000;
  localparam logic [CntW-1:0]     DivLast      = CntW'(NumW - 1);

  typedef struct packed {
    logic mode;
    logic heating_on;
    logic eta_valid;
    logic [LocalW-1:0] local_time_us;
    logic [EpochW-1:0] wall_time_ms;
    logic [EpochW-1:0] observed_time_ms;
    logic [EpochW-1:0] ready_time_ms;
  } hecd_item_t;

  typedef struct packed {
    logic diff_en;
    logic mul_en;
    logic sum_en;
    logic commit;
    logic eval_en;
  } hecd_ctrl_t;

  typedef struct packed {
    logic ok;
    logic present;
    logic run;
    logic full;
  } hecd_stat_t;

endpackage

// ===== rtl/heat_eta_countdown_tracker_unit.sv =====
// Top level of the heating ETA countdown tracker: sequencer, output register, divider.
// Sequence: diff, multiply, sum, commit, evaluate and start states, then the 68-step
// bit-serial divider when a permille division is needed, then the output register load.
// A new input is taken only after the previous result is loaded; the next input is taken
// while the previous result still waits in the output register.
// Reset: asynchronous active low; clears the session to no heating, no start, no deadline.
module heat_eta_countdown_tracker_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           mode_i,
  input  logic                           heating_on_i,
  input  logic                           eta_valid_i,
  input  logic [hecd_pkg::LocalW-1:0]    local_time_us_i,
  input  logic [hecd_pkg::EpochW-1:0]    wall_time_ms_i,
  input  logic [hecd_pkg::EpochW-1:0]    observed_time_ms_i,
  input  logic [hecd_pkg::EpochW-1:0]    ready_time_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           update_ok_o,
  output logic                           eta_present_o,
  output logic [hecd_pkg::DlW-1:0]       left_us_o,
  output logic [hecd_pkg::PmW-1:0]       left_permille_o
);
  import hecd_pkg::*;

  typedef enum logic [8:0] {
    StIdle   = 9'b000000001,
    StDiff   = 9'b000000010,
    StMul    = 9'b000000100,
    StSum    = 9'b000001000,
    StCommit = 9'b000010000,
    StEval   = 9'b000100000,
    StStart  = 9'b001000000,
    StDiv    = 9'b010000000,
    StOut    = 9'b100000000
  } state_e;

  state_e         state_q, state_d;
  hecd_item_t     item_q;
  hecd_ctrl_t     ctrl;
  hecd_stat_t     stat;
  logic [DlW-1:0] left, total;
  logic           div_start, div_done;
  logic [PmW-1:0] quot;
  logic           in_fire, out_load;

  logic           out_valid_q, out_valid_d;
  logic           ok_q;
  logic           present_q;
  logic [DlW-1:0] left_us_q;
  logic [PmW-1:0] pm_q;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == StOut) && (!out_valid_q || out_ready_i);
  assign div_start  = (state_q == StStart) && stat.run && !stat.full;

  assign ctrl.diff_en = (state_q == StDiff);
  assign ctrl.mul_en  = (state_q == StMul);
  assign ctrl.sum_en  = (state_q == StSum);
  assign ctrl.commit  = (state_q == StCommit);
  assign ctrl.eval_en = (state_q == StEval);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (in_fire) state_d = StDiff;
      StDiff:   state_d = StMul;
      StMul:    state_d = StSum;
      StSum:    state_d = StCommit;
      StCommit: state_d = StEval;
      StEval:   state_d = StStart;
      StStart:  state_d = div_start ? StDiv : StOut;
      StDiv:    if (div_done) state_d = StOut;
      StOut:    if (out_load) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.mode             <= mode_i;
      item_q.heating_on       <= heating_on_i;
      item_q.eta_valid        <= eta_valid_i;
      item_q.local_time_us    <= local_time_us_i;
      item_q.wall_time_ms     <= wall_time_ms_i;
      item_q.observed_time_ms <= observed_time_ms_i;
      item_q.ready_time_ms    <= ready_time_ms_i;
    end
    if (out_load) begin
      ok_q      <= stat.ok;
      present_q <= stat.present;
      left_us_q <= stat.run ? left : '0;
      pm_q      <= !stat.run ? '0 : (stat.full ? PermilleFull : quot);
    end
  end

  hecd_calc u_calc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .item_i  (item_q),
    .stat_o  (stat),
    .left_o  (left),
    .total_o (total)
  );

  hecd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .left_i  (left),
    .den_i   (total),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign out_valid_o     = out_valid_q;
  assign update_ok_o     = ok_q;
  assign eta_present_o   = present_q;
  assign left_us_o       = left_us_q;
  assign left_permille_o = pm_q;

  a_pm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> left_permille_o <= PermilleFull)
    else $error("permille above full scale");

  a_no_eta_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !eta_present_o |-> left_us_o == '0 && left_permille_o == '0)
    else $error("remaining time reported without an ETA");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again before transaction finished");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == StDiv)
    else $error("divider finished outside divide state");

endmodule

// ===== rtl/hecd_div.sv =====
// Bit-serial restoring divider: permille quotient of left*1000 over session length.
module hecd_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [hecd_pkg::DlW-1:0]      left_i,
  input  logic [hecd_pkg::DlW-1:0]      den_i,
  output logic                          done_o,
  output logic [hecd_pkg::PmW-1:0]      quot_o
);
  import hecd_pkg::*;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] num_q, num_d;
  logic [DlW-1:0]  rem_q, rem_d;
  logic [DlW-1:0]  den_q, den_d;
  logic [PmW-1:0]  quo_q, quo_d;
  logic [DlW:0]    trial;
  logic            ge;

  assign trial = {rem_q, num_q[NumW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = NumW'(left_i) * NumW'(UsPerMs);
      rem_d  = '0;
      den_d  = den_i;
      quo_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[NumW-2:0], 1'b0};
      rem_d = ge ? DlW'(trial - {1'b0, den_q}) : trial[DlW-1:0];
      quo_d = {quo_q[PmW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== rtl/hecd_calc.sv =====
// Session state and update arithmetic: remaining time, deadline, start and evaluation.
module hecd_calc (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hecd_pkg::hecd_ctrl_t          ctrl_i,
  input  hecd_pkg::hecd_item_t          item_i,
  output hecd_pkg::hecd_stat_t          stat_o,
  output logic [hecd_pkg::DlW-1:0]      left_o,
  output logic [hecd_pkg::DlW-1:0]      total_o
);
  import hecd_pkg::*;

  logic                     heat_q;
  logic [LocalW-1:0]        start_q;
  logic [DlW-1:0]           dl_q;
  logic [EpochW-1:0]        src_q;

  logic                     direct_q;
  logic signed [MopW-1:0]   mop_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [SumW-1:0]   sum_q;
  logic                     cond_q;
  logic                     upd_q;
  logic                     ok_q, present_q, run_q;
  logic [DlW-1:0]           left_q, total_q;

  logic                     use_obs, use_wall;
  logic [EpochW-1:0]        diff;
  logic signed [MopW-1:0]   delta;
  logic signed [ProdW:0]    prod_full;
  logic                     valid, upd, present;
  logic [LocalW-1:0]        now;
  logic [EpochW-1:0]        ready;

  assign now   = item_i.local_time_us;
  assign ready = item_i.ready_time_ms;

  assign use_obs  = (item_i.observed_time_ms != '0) && (ready > item_i.observed_time_ms);
  assign use_wall = (item_i.wall_time_ms != '0) && (ready > item_i.wall_time_ms);
  assign diff     = use_obs ? ready - item_i.observed_time_ms : ready - item_i.wall_time_ms;
  assign delta    = $signed({1'b0, ready}) - $signed({1'b0, src_q});
  assign prod_full = mop_q * UsPerMs;

  assign valid = direct_q || (cond_q && !sum_q[SumW-1] &&
                              (sum_q[SumW-2:0] > (SumW-1)'(now)));
  assign upd   = !item_i.mode && item_i.heating_on && item_i.eta_valid &&
                 (ready != '0) && valid;

  assign present = heat_q && (start_q != '0) && (dl_q != '0) && (dl_q > DlW'(start_q));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.diff_en) begin
      direct_q <= use_obs || use_wall;
      mop_q    <= (use_obs || use_wall) ? $signed({1'b0, diff}) : delta;
    end
    if (ctrl_i.mul_en) begin
      prod_q <= prod_full[ProdW-1:0];
    end
    if (ctrl_i.sum_en) begin
      sum_q  <= direct_q ? $signed(SumW'(now)) + SumW'(prod_q)
                         : $signed(SumW'(dl_q)) + SumW'(prod_q);
      cond_q <= (dl_q > DlW'(now)) && (src_q != '0);
    end
    if (ctrl_i.commit) begin
      upd_q <= upd;
    end
    if (ctrl_i.eval_en) begin
      ok_q      <= !item_i.mode && item_i.heating_on && (upd_q || present);
      present_q <= present;
      run_q     <= present && (dl_q > DlW'(now));
      left_q    <= dl_q - DlW'(now);
      total_q   <= dl_q - DlW'(start_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heat_q  <= 1'b0;
      start_q <= '0;
      dl_q    <= '0;
      src_q   <= '0;
    end else if (ctrl_i.commit && !item_i.mode) begin
      if (!item_i.heating_on) begin
        heat_q  <= 1'b0;
        start_q <= '0;
        dl_q    <= '0;
        src_q   <= '0;
      end else begin
        heat_q <= 1'b1;
        if (upd) begin
          if (start_q == '0 || start_q > now) begin
            start_q <= now;
          end
          dl_q  <= sum_q[SumW-2] ? DlMax : sum_q[DlW-1:0];
          src_q <= ready;
        end
      end
    end
  end

  assign stat_o.ok      = ok_q;
  assign stat_o.present = present_q;
  assign stat_o.run     = run_q;
  assign stat_o.full    = left_q >= total_q;
  assign left_o         = left_q;
  assign total_o        = total_q;

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the heating ETA countdown tracker with its own session model.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hecd_pkg::*;

  localparam int IdleLimit = 20000;
  localparam int TailCycles = 100;
  localparam int RandomItems = 1600;
  localparam int LongHoldCycles = 400;
  localparam logic [LocalW-1:0] T0 = 48'd1000000;

  typedef struct packed {
    logic ok;
    logic present;
    logic [DlW-1:0] left_us;
    logic [PmW-1:0] permille;
  } eta_status_t;

  typedef struct {
    hecd_item_t item;
    int gap;
    bit drain;
  } request_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready_o;
  hecd_item_t in_item = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  logic update_ok_o;
  logic eta_present_o;
  logic [DlW-1:0] left_us_o;
  logic [PmW-1:0] left_permille_o;

  request_t request_q[$];
  eta_status_t eta_status_q[$];

  // session model
  logic heat_on_st = 1'b0;
  logic [LocalW-1:0] start_us = '0;
  logic [DlW-1:0] deadline_us = '0;
  logic [EpochW-1:0] src_ready_ms = '0;

  bit calm_phase = 1'b0;
  int err_cnt = 0;

  heat_eta_countdown_tracker_unit u_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready_o),
    .mode_i             (in_item.mode),
    .heating_on_i       (in_item.heating_on),
    .eta_valid_i        (in_item.eta_valid),
    .local_time_us_i    (in_item.local_time_us),
    .wall_time_ms_i     (in_item.wall_time_ms),
    .observed_time_ms_i (in_item.observed_time_ms),
    .ready_time_ms_i    (in_item.ready_time_ms),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready),
    .update_ok_o        (update_ok_o),
    .eta_present_o      (eta_present_o),
    .left_us_o          (left_us_o),
    .left_permille_o    (left_permille_o)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [LocalW-1:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [EpochW-1:0] rand47();
    return {15'($urandom), 32'($urandom)};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 50);
  endfunction

  function automatic bit session_live();
    return heat_on_st && start_us != '0 && deadline_us != '0 &&
           deadline_us > DlW'(start_us);
  endfunction

  function automatic longint calc_rem_us(hecd_item_t it);
    longint rdy, obs, wall, rem;
    rdy = it.ready_time_ms;
    obs = it.observed_time_ms;
    wall = it.wall_time_ms;
    if (obs != 0 && rdy > obs) return (rdy - obs) * longint'(UsPerMs);
    if (wall != 0 && rdy > wall) return (rdy - wall) * longint'(UsPerMs);
    if (deadline_us <= DlW'(it.local_time_us) || src_ready_ms == '0) return 0;
    rem = longint'(deadline_us) - longint'(it.local_time_us);
    if (src_ready_ms == it.ready_time_ms) return rem;
    rem += (rdy - longint'(src_ready_ms)) * longint'(UsPerMs);
    return (rem > 0) ? rem : 0;
  endfunction

  function automatic eta_status_t track_item(hecd_item_t it);
    eta_status_t r;
    longint rem;
    logic [SumW-1:0] dl;
    logic [DlW-1:0] total;
    logic [NumW-1:0] scaled;
    r = '0;
    if (it.mode == 1'b0) begin
      if (!it.heating_on) begin
        heat_on_st = 1'b0;
        start_us = '0;
        deadline_us = '0;
        src_ready_ms = '0;
      end else begin
        heat_on_st = 1'b1;
        if (!it.eta_valid || it.ready_time_ms == '0) begin
          r.ok = session_live();
        end else begin
          rem = calc_rem_us(it);
          if (rem <= 0) begin
            r.ok = session_live();
          end else begin
            if (start_us == '0 || start_us > it.local_time_us) start_us = it.local_time_us;
            dl = SumW'(it.local_time_us) + SumW'(rem);
            deadline_us = (dl > SumW'(DlMax)) ? DlMax : dl[DlW-1:0];
            src_ready_ms = it.ready_time_ms;
            r.ok = 1'b1;
          end
        end
      end
    end
    r.present = session_live();
    if (r.present && DlW'(it.local_time_us) < deadline_us) begin
      total = deadline_us - DlW'(start_us);
      r.left_us = deadline_us - DlW'(it.local_time_us);
      if (r.left_us >= total) begin
        r.permille = PermilleFull;
      end else begin
        scaled = NumW'(r.left_us) * NumW'(PermilleFull) / NumW'(total);
        r.permille = scaled[PmW-1:0];
      end
    end
    return r;
  endfunction

  task automatic queue_item(logic m, logic h, logic e, logic [LocalW-1:0] lt,
                            logic [EpochW-1:0] w, logic [EpochW-1:0] o,
                            logic [EpochW-1:0] rdy, bit drain = 1'b0);
    request_t s;
    s.item = '{mode: m, heating_on: h, eta_valid: e, local_time_us: lt,
               wall_time_ms: w, observed_time_ms: o, ready_time_ms: rdy};
    s.gap = calm_phase ? 0 : pick_gap();
    s.drain = drain;
    request_q.push_back(s);
  endtask

  // driver
  bit accepted;
  bit head_armed = 1'b0;
  int spacing = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      accepted = in_valid && in_ready_o;
      if (accepted) begin
        eta_status_q.push_back(track_item(request_q[0].item));
        void'(request_q.pop_front());
        head_armed = 1'b0;
      end
      if (!(in_valid && !accepted)) begin
        if (request_q.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          if (!head_armed) begin
            spacing = request_q[0].gap;
            head_armed = 1'b1;
          end
          if (request_q[0].drain && eta_status_q.size() != 0) begin
            in_valid <= 1'b0;
          end else if (spacing > 0) begin
            spacing--;
            in_valid <= 1'b0;
          end else begin
            in_valid <= 1'b1;
            in_item <= request_q[0].item;
          end
        end
      end
    end
  end

  // monitor
  int cyc_cnt = 0;
  int results_seen = 0;
  int rx_gap = 0;
  int long_hold = 0;
  int next_hold_at = 120;
  eta_status_t got, want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      cyc_cnt++;
      if (out_valid_o && out_ready) begin
        results_seen++;
        rx_gap = ((cyc_cnt / 512) % 4 == 0) ? 0 : pick_gap();
        got = '{ok: update_ok_o, present: eta_present_o, left_us: left_us_o,
                permille: left_permille_o};
        if (eta_status_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected transaction %0d: ok %0b present %0b left_us %0d permille %0d",
                     results_seen, got.ok, got.present, got.left_us, got.permille);
        end else begin
          want = eta_status_q.pop_front();
          if (got.ok !== want.ok || got.present !== want.present ||
              got.left_us !== want.left_us || got.permille !== want.permille) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display({"transaction %0d mismatch (exp/act): ok %0b/%0b present %0b/%0b ",
                        "left_us %0d/%0d permille %0d/%0d"},
                       results_seen, want.ok, got.ok, want.present, got.present,
                       want.left_us, got.left_us, want.permille, got.permille);
          end
        end
      end
      if (long_hold == 0 && results_seen >= next_hold_at) begin
        long_hold = LongHoldCycles;
        next_hold_at += 800;
      end
      if (long_hold > 0) begin
        long_hold--;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  int idle_cnt = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IdleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int n, sel, path;
    bit drain;
    logic [LocalW-1:0] now_us, lt;
    logic [EpochW-1:0] epoch_ms, rdy, obs, wall, prev_rdy;

    // directed
    queue_item(1'b1, 1'b0, 1'b0, '0, '0, '0, '0);
    queue_item(1'b0, 1'b1, 1'b0, T0, 47'd1000, 47'd1000, 47'd1500);
    queue_item(1'b0, 1'b1, 1'b1, T0, 47'd1000, 47'd1000, 47'd0);
    queue_item(1'b0, 1'b1, 1'b1, T0, 47'd0, 47'd1000, 47'd1500);
    queue_item(1'b1, 1'b0, 1'b0, T0 + 48'd100000, '0, '0, '0);
    queue_item(1'b1, 1'b1, 1'b1, T0 - 48'd5000, '0, '0, '0);
    queue_item(1'b0, 1'b1, 1'b1, T0 + 48'd200000, 47'd2000, 47'd0, 47'd2300);
    queue_item(1'b0, 1'b1, 1'b1, T0 + 48'd300000, 47'd0, 47'd0, 47'd2400);
    queue_item(1'b0, 1'b1, 1'b1, T0 + 48'd350000, 47'd2400, 47'd3000, 47'd2400);
    queue_item(1'b0, 1'b1, 1'b1, T0 + 48'd360000, 47'd0, 47'd0, 47'd1);
    queue_item(1'b1, 1'b0, 1'b0, T0 + 48'd700000, '0, '0, '0);
    queue_item(1'b0, 1'b1, 1'b1, T0 + 48'd800000, 47'd0, 47'd0, 47'd2500);
    queue_item(1'b0, 1'b1, 1'b1, T0 - 48'd100000, 47'd0, 47'd1, 47'd50);
    queue_item(1'b1, 1'b0, 1'b0, T0, '0, '0, '0);
    queue_item(1'b0, 1'b0, 1'b1, T0, 47'd1, 47'd1, 47'd10);
    queue_item(1'b0, 1'b1, 1'b1, '0, 47'd0, 47'd1, 47'd10);
    queue_item(1'b1, 1'b0, 1'b0, '0, '0, '0, '0);
    queue_item(1'b0, 1'b0, 1'b0, '1, '1, '1, '1);
    queue_item(1'b0, 1'b1, 1'b1, '1, 47'd0, 47'd1, '1);
    queue_item(1'b1, 1'b0, 1'b0, '0, '0, '0, '0);
    queue_item(1'b1, 1'b1, 1'b1, '1, '1, '1, '1);
    queue_item(1'b0, 1'b0, 1'b1, '1, '1, '1, '1);
    queue_item(1'b0, 1'b1, 1'b1, T0, '1, '1, '1);

    // random sessions
    now_us = 48'($urandom);
    epoch_ms = 47'd1700000000000 + 47'($urandom_range(0, 100000000));
    prev_rdy = epoch_ms;
    for (n = 0; n < RandomItems; n++) begin
      calm_phase = ((n / 100) % 4) == 2;
      drain = (n % 300) == 0;
      if ($urandom_range(0, 49) == 0) begin
        now_us = rand48();
        epoch_ms = rand47();
      end
      now_us += 48'($urandom_range(0, 400000));
      epoch_ms += 47'($urandom_range(0, 400));
      lt = ($urandom_range(0, 19) == 0) ? now_us - 48'($urandom_range(0, 2000000)) : now_us;
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        queue_item(1'($urandom), 1'($urandom), 1'($urandom), rand48(), rand47(), rand47(),
                   rand47(), drain);
      end else if (sel < 14) begin
        queue_item(1'b0, 1'b0, 1'($urandom), lt, rand47(), rand47(), rand47(), drain);
      end else if (sel < 20) begin
        if ($urandom_range(0, 1) == 0)
          queue_item(1'b0, 1'b1, 1'b0, lt, rand47(), rand47(), rand47(), drain);
        else queue_item(1'b0, 1'b1, 1'b1, lt, rand47(), rand47(), '0, drain);
      end else if (sel < 45) begin
        queue_item(1'b1, 1'($urandom), 1'($urandom), lt, rand47(), rand47(), rand47(), drain);
      end else begin
        path = $urandom_range(0, 2);
        if (path == 2 || $urandom_range(0, 9) == 0)
          rdy = prev_rdy + 47'($urandom_range(0, 400000)) - 47'd200000;
        else
          rdy = epoch_ms + 47'($urandom_range(1, 900000));
        if (rdy == '0) rdy = 47'd1;
        obs = ($urandom_range(0, 1) == 0) ? 47'd0 : rdy + 47'($urandom_range(0, 5000));
        wall = ($urandom_range(0, 1) == 0) ? 47'd0 : rdy + 47'($urandom_range(0, 5000));
        if (path == 0) obs = epoch_ms - 47'($urandom_range(0, 5000));
        else if (path == 1) wall = epoch_ms;
        queue_item(1'b0, 1'b1, 1'b1, lt, wall, obs, rdy, drain);
        prev_rdy = rdy;
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wait (request_q.size() == 0 && !in_valid);
    wait (eta_status_q.size() == 0);
    repeat (TailCycles) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
